FILE: src/lz3d_pkg.sv
// shared types, codes and helpers of the lz3 stream decompressor
package lz3d_pkg;

  localparam int unsigned HistoryDepthDefault = 65536;
  localparam int unsigned CountWidth = 17;
  localparam logic [CountWidth-1:0] LimitReset = 17'h10000;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       want_byte;
    logic       done_res;
    logic [2:0] error_code;
    logic       req_rejected;
  } result_t;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_PULL = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_PULL,
    KIND_END,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } word_t;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SRC_END = 3'd1;
  localparam logic [2:0] ERR_BADREF  = 3'd2;
  localparam logic [2:0] ERR_REVERSE = 3'd3;
  localparam logic [2:0] ERR_LIMIT   = 3'd4;
  localparam logic [2:0] ERR_EMPTY   = 3'd5;

  localparam logic [2:0] CMD_LITERAL = 3'd0;
  localparam logic [2:0] CMD_FILL    = 3'd1;
  localparam logic [2:0] CMD_ALT     = 3'd2;
  localparam logic [2:0] CMD_ZERO    = 3'd3;
  localparam logic [2:0] CMD_COPY    = 3'd4;
  localparam logic [2:0] CMD_BITREV  = 3'd5;
  localparam logic [2:0] CMD_REVERSE = 3'd6;
  localparam logic [2:0] CMD_EXT     = 3'd7;

  localparam logic [7:0] CTRL_END = 8'hFF;

  function automatic logic [7:0] bit_reverse(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

FILE: src/lz3d_front.sv
// front end: takes request words, classifies them and queues them for the back end
module lz3d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  lz3d_pkg::item_t item,
  output logic            q_valid,
  input  logic            q_ready,
  output lz3d_pkg::word_t q_word
);

  lz3d_pkg::word_t slot [2];
  logic            wp;
  logic            rp;
  logic [1:0]      fill;
  lz3d_pkg::word_t cls;
  logic            push;
  logic            pop;

  always_comb begin
    cls.data = item.in_byte;
    case (item.req_type)
      lz3d_pkg::REQ_PUSH: cls.kind = lz3d_pkg::KIND_PUSH;
      lz3d_pkg::REQ_PULL: cls.kind = lz3d_pkg::KIND_PULL;
      lz3d_pkg::REQ_END:  cls.kind = lz3d_pkg::KIND_END;
      default:            cls.kind = lz3d_pkg::KIND_BAD;
    endcase
  end

  assign item_ready = (fill != 2'd2);
  assign q_valid    = (fill != 2'd0);
  assign q_word     = slot[rp];
  assign push       = item_valid && item_ready;
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd0 |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

FILE: src/lz3d_back.sv
// back end: stream state machine, history memory and result register
module lz3d_back #(
  parameter int unsigned HISTORY_DEPTH = lz3d_pkg::HistoryDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  lz3d_pkg::word_t   q_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [16:0]       cfg_data,
  output logic              result_valid,
  input  logic              result_ready,
  output lz3d_pkg::result_t result
);

  localparam int unsigned CW = lz3d_pkg::CountWidth;
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned XW = (AW > CW) ? AW : CW;

  typedef enum logic [3:0] {
    PH_CTRL, PH_LONG, PH_LIT_IN, PH_LIT_OUT, PH_FILL_IN, PH_ALT_A,
    PH_ALT_B, PH_RUN, PH_OFF_A, PH_OFF_B, PH_DONE
  } phase_t;

  typedef struct packed {
    logic          out_valid;
    logic          use_mem;
    logic          rev;
    logic          fwd;
    logic [7:0]    fwd_byte;
    logic [7:0]    lit;
    logic [AW-1:0] waddr;
    logic          want_byte;
    logic          done_res;
    logic [2:0]    error_code;
    logic          req_rejected;
  } stage_t;

  logic [7:0]    mem [HISTORY_DEPTH];
  logic [7:0]    rdata;

  phase_t        phase, phase_next;
  logic [2:0]    err, err_next;
  logic [2:0]    command, command_next;
  logic [10:0]   run_left, run_left_next;
  logic [1:0]    long_hi, long_hi_next;
  logic [7:0]    fill_first, fill_first_next;
  logic [7:0]    fill_second, fill_second_next;
  logic          parity, parity_next;
  logic [7:0]    offset_high, offset_high_next;
  logic [CW-1:0] copy_source, copy_source_next;
  logic [CW-1:0] produced, produced_next;
  logic [CW-1:0] output_limit;

  stage_t        s2, s2_next;
  logic          s2_v;
  logic [7:0]    s2_byte;
  logic [7:0]    s2_src;

  logic          en;
  logic          take;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  assign en        = !result_valid || result_ready;
  assign q_ready   = en;
  assign take      = en && q_valid;
  assign cfg_ready = 1'b1;

  // position modulo the history depth; positions stay below four depths
  function automatic logic [AW-1:0] hist_addr(input logic [CW-1:0] p);
    logic [XW:0] x;
    x = (XW + 1)'(p);
    for (int k = 0; k < 3; k++) begin
      if (x >= (XW + 1)'(HISTORY_DEPTH)) begin
        x = x - (XW + 1)'(HISTORY_DEPTH);
      end
    end
    return x[AW-1:0];
  endfunction

  assign raddr  = hist_addr(copy_source);
  assign waddr  = hist_addr(produced);

  function automatic logic wants(input phase_t p);
    case (p)
      PH_CTRL, PH_LONG, PH_LIT_IN, PH_FILL_IN,
      PH_ALT_A, PH_ALT_B, PH_OFF_A, PH_OFF_B: return 1'b1;
      default:                                return 1'b0;
    endcase
  endfunction

  function automatic phase_t run_phase(input logic [2:0] cmd);
    case (cmd)
      lz3d_pkg::CMD_LITERAL: return PH_LIT_IN;
      lz3d_pkg::CMD_FILL:    return PH_FILL_IN;
      lz3d_pkg::CMD_ALT:     return PH_ALT_A;
      lz3d_pkg::CMD_ZERO:    return PH_RUN;
      default:               return PH_OFF_A;
    endcase
  endfunction

  // result byte of the item in the second stage
  assign s2_src  = s2.fwd ? s2.fwd_byte : rdata;
  assign s2_byte = !s2.out_valid ? 8'd0 :
                   !s2.use_mem   ? s2.lit :
                   s2.rev        ? lz3d_pkg::bit_reverse(s2_src) : s2_src;

  always_comb begin
    logic          want;
    logic          has_src;
    logic [CW-1:0] src;
    logic [7:0]    b;

    phase_next       = phase;
    err_next         = err;
    command_next     = command;
    run_left_next    = run_left;
    long_hi_next     = long_hi;
    fill_first_next  = fill_first;
    fill_second_next = fill_second;
    parity_next      = parity;
    offset_high_next = offset_high;
    copy_source_next = copy_source;
    produced_next    = produced;
    want             = wants(phase);
    has_src          = 1'b0;
    src              = '0;
    b                = q_word.data;

    s2_next              = '0;
    s2_next.waddr        = waddr;
    s2_next.fwd          = s2_v && s2.out_valid && (s2.waddr == raddr);
    s2_next.fwd_byte     = s2_byte;

    if (take) begin
      if (phase == PH_DONE || q_word.kind == lz3d_pkg::KIND_BAD ||
          (want && q_word.kind == lz3d_pkg::KIND_PULL) ||
          (!want && q_word.kind != lz3d_pkg::KIND_PULL)) begin
        s2_next.req_rejected = 1'b1;
      end else if (q_word.kind == lz3d_pkg::KIND_END) begin
        phase_next = PH_DONE;
        err_next   = lz3d_pkg::ERR_SRC_END;
      end else if (q_word.kind == lz3d_pkg::KIND_PUSH) begin
        case (phase)
          PH_CTRL: begin
            if (b == lz3d_pkg::CTRL_END) begin
              phase_next = PH_DONE;
              err_next   = (produced == '0) ? lz3d_pkg::ERR_EMPTY : lz3d_pkg::ERR_NONE;
            end else if (b[7:5] == lz3d_pkg::CMD_EXT) begin
              command_next = b[4:2];
              long_hi_next = b[1:0];
              phase_next   = PH_LONG;
            end else begin
              command_next  = b[7:5];
              run_left_next = {6'd0, b[4:0]} + 11'd1;
              phase_next    = run_phase(b[7:5]);
              if (b[7:5] == lz3d_pkg::CMD_ALT) begin
                parity_next = 1'b0;
              end
            end
          end
          PH_LONG: begin
            run_left_next = {1'b0, long_hi, b} + 11'd1;
            phase_next    = run_phase(command);
            if (command == lz3d_pkg::CMD_ALT) begin
              parity_next = 1'b0;
            end
          end
          PH_LIT_IN: begin
            fill_first_next = b;
            phase_next      = PH_LIT_OUT;
          end
          PH_FILL_IN: begin
            fill_first_next = b;
            phase_next      = PH_RUN;
          end
          PH_ALT_A: begin
            fill_first_next = b;
            phase_next      = PH_ALT_B;
          end
          PH_ALT_B: begin
            fill_second_next = b;
            phase_next       = PH_RUN;
          end
          PH_OFF_A: begin
            if (b[7]) begin
              if (CW'(b[6:0]) >= produced) begin
                phase_next = PH_DONE;
                err_next   = lz3d_pkg::ERR_BADREF;
              end else begin
                has_src = 1'b1;
                src     = produced - CW'(b[6:0]) - CW'(1);
              end
            end else begin
              offset_high_next = b;
              phase_next       = PH_OFF_B;
            end
          end
          PH_OFF_B: begin
            if (CW'({offset_high, b}) >= produced) begin
              phase_next = PH_DONE;
              err_next   = lz3d_pkg::ERR_BADREF;
            end else begin
              has_src = 1'b1;
              src     = CW'({offset_high, b});
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
        if (has_src) begin
          copy_source_next = src;
          if (command == lz3d_pkg::CMD_REVERSE &&
              ({1'b0, src} + (CW + 1)'(1)) < (CW + 1)'(run_left)) begin
            phase_next = PH_DONE;
            err_next   = lz3d_pkg::ERR_REVERSE;
          end else if (command == lz3d_pkg::CMD_EXT) begin
            phase_next = PH_CTRL;
          end else begin
            phase_next = PH_RUN;
          end
        end
      end else begin
        // pull: one output byte unless the limit is reached
        if (produced >= output_limit) begin
          phase_next = PH_DONE;
          err_next   = lz3d_pkg::ERR_LIMIT;
        end else begin
          s2_next.out_valid = 1'b1;
          if (phase == PH_LIT_OUT) begin
            s2_next.lit = fill_first;
          end else begin
            case (command)
              lz3d_pkg::CMD_FILL: s2_next.lit = fill_first;
              lz3d_pkg::CMD_ALT: begin
                s2_next.lit = parity ? fill_second : fill_first;
                parity_next = ~parity;
              end
              lz3d_pkg::CMD_ZERO: s2_next.lit = 8'd0;
              lz3d_pkg::CMD_COPY: begin
                s2_next.use_mem  = 1'b1;
                copy_source_next = copy_source + CW'(1);
              end
              lz3d_pkg::CMD_BITREV: begin
                s2_next.use_mem  = 1'b1;
                s2_next.rev      = 1'b1;
                copy_source_next = copy_source + CW'(1);
              end
              default: begin
                s2_next.use_mem  = 1'b1;
                copy_source_next = copy_source - CW'(1);
              end
            endcase
          end
          produced_next = produced + CW'(1);
          run_left_next = run_left - 11'd1;
          if (run_left_next == 11'd0) begin
            phase_next = PH_CTRL;
          end else if (phase == PH_LIT_OUT) begin
            phase_next = PH_LIT_IN;
          end
        end
      end
    end

    s2_next.want_byte  = wants(phase_next);
    s2_next.done_res   = (phase_next == PH_DONE);
    s2_next.error_code = (phase_next == PH_DONE) ? err_next : lz3d_pkg::ERR_NONE;
  end

  // history: read issued in the first stage, write from the second
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_v && s2.out_valid) begin
      mem[s2.waddr] <= s2_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
      result.out_valid    <= s2.out_valid;
      result.out_byte     <= s2_byte;
      result.want_byte    <= s2.want_byte;
      result.done_res     <= s2.done_res;
      result.error_code   <= s2.error_code;
      result.req_rejected <= s2.req_rejected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CTRL;
      err          <= lz3d_pkg::ERR_NONE;
      command      <= '0;
      run_left     <= '0;
      long_hi      <= '0;
      fill_first   <= '0;
      fill_second  <= '0;
      parity       <= 1'b0;
      offset_high  <= '0;
      copy_source  <= '0;
      produced     <= '0;
      output_limit <= lz3d_pkg::LimitReset;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      phase       <= phase_next;
      err         <= err_next;
      command     <= command_next;
      run_left    <= run_left_next;
      long_hi     <= long_hi_next;
      fill_first  <= fill_first_next;
      fill_second <= fill_second_next;
      parity      <= parity_next;
      offset_high <= offset_high_next;
      copy_source <= copy_source_next;
      produced    <= produced_next;
      if (cfg_valid && cfg_ready) begin
        output_limit <= cfg_data;
      end
      if (en) begin
        s2_v         <= take;
        result_valid <= s2_v;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_rej_no_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.req_rejected |-> !result.out_valid)
    else $error("rejected word carries a byte");
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.error_code != lz3d_pkg::ERR_NONE) |-> result.done_res)
    else $error("error code without done");
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("left done state without reset");
`endif

endmodule

FILE: src/lz3_stream_decompressor.sv
// lz3 stream decompressor top level
// path: an accepted request word passes the front queue, the second stage and the result register
// throughput: one request word per cycle, including copies, unless result_ready stalls the output; the history memory
// gives one read and one write a cycle, with forwarding of the byte just written
// reset: synchronous rst clears stream state and queues, output limit returns to 65536
// the history memory has no clearing pass; entries are read only after being written
module lz3_stream_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lz3d_pkg::HistoryDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lz3d_pkg::item_t   item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [16:0]       cfg_data,
  output logic              result_valid,
  input  logic              result_ready,
  output lz3d_pkg::result_t result
);

  logic            q_valid;
  logic            q_ready;
  lz3d_pkg::word_t q_word;

  lz3d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_word     (q_word)
  );

  lz3d_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_word       (q_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
